// ===== src/nqst_pkg.sv =====
// Shared constants and codes for the note queue square tone player.
// No dependencies; imported by the top level, its checker and the bench.
`timescale 1ns / 1ps
`default_nettype none
package nqst_pkg;
	localparam int QUEUE_DEPTH = 256;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam int DDW = 28;
	localparam int DVW = 17;
	localparam int DCW = $clog2(DDW);

	localparam logic [27:0] ELAPSED_MAX = 28'h7FF_FFFF;
	localparam logic [19:0] HALF_MEGA = 20'd500000;
	localparam logic [19:0] CLK_MEGA = 20'd1000000;
	localparam logic [9:0] MS_TO_US = 10'd1000;
	localparam logic [7:0] CLK_RESET = 8'd84;
	localparam logic [31:0] RELOAD_RESET = 32'd1000;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_START = 2'd2
	} mode_t;
endpackage
`default_nettype wire

// ===== src/note_queue_square_tone_player.sv =====
// Beeper sequencer: note ring buffer, shared restoring divider and a small sequencer.
// Depends on nqst_pkg. An add, an ignored word or a start on an empty queue goes straight
// to the result; a tone update runs 28 divider steps and pops when the note ends, a rest
// update pops at once; a reload after a pop or a start divides for a tone, multiplies for
// a rest. Next word taken as the result rises; a stalled result holds the one after.
// Reset clears queue pointers, pin, enable and reload (1000); clock setting returns to 84.
`timescale 1ns / 1ps
`default_nettype none
module note_queue_square_tone_player import nqst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] freq_hz,
	input  wire logic [15:0] duration_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             pin_level,
	output logic [31:0]      reload_value,
	output logic             events_enabled,
	output logic [8:0]       notes_waiting,
	output logic             add_refused,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  timer_clock_mhz
);
	typedef enum logic [3:0] {
		S_IDLE, S_URD, S_UHEAD, S_UDIV, S_UACC, S_POP,
		S_RRD, S_RHEAD, S_RDIV, S_RSET, S_RMUL, S_DONE
	} state_t;

	state_t state_q;

	logic [31:0] note_store [QUEUE_DEPTH];
	logic [31:0] rd_data_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [26:0] elapsed_q;
	logic pin_q;
	logic enable_q;
	logic [31:0] reload_q;
	logic refused_q;
	logic [25:0] limit_q;
	logic [33:0] prod_q;
	logic [27:0] clk_m_q;
	logic [17:0] clk_k_q;

	logic [DDW-1:0] quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [DCW-1:0] div_cnt_q;

	logic accept;
	logic wr_en;
	logic [AW:0] wr_sum;
	logic [AW-1:0] wr_addr;
	logic [DVW:0] rem_shift;
	logic rem_ge;
	logic [DVW-1:0] rem_next;
	logic [27:0] elapsed_sum;
	logic [26:0] elapsed_sat;
	logic [15:0] head_freq;
	logic [15:0] head_dur;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;

	assign wr_sum = {1'b0, head_q} + (AW+1)'(count_q);
	assign wr_addr = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(wr_sum - (AW+1)'(QUEUE_DEPTH)) : wr_sum[AW-1:0];
	assign wr_en = accept && (mode == MODE_ADD) && (count_q < CW'(QUEUE_DEPTH));

	assign head_freq = rd_data_q[31:16];
	assign head_dur = rd_data_q[15:0];

	assign rem_shift = {rem_q, quo_q[DDW-1]};
	assign rem_ge = (rem_shift >= {1'b0, dvs_q});
	assign rem_next = rem_ge ? DVW'(rem_shift - {1'b0, dvs_q}) : rem_shift[DVW-1:0];

	assign elapsed_sum = {1'b0, elapsed_q} + quo_q;
	assign elapsed_sat = (elapsed_sum > ELAPSED_MAX) ? ELAPSED_MAX[26:0] : elapsed_sum[26:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			note_store[wr_addr] <= {freq_hz, duration_ms};
		end
		rd_data_q <= note_store[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_m_q <= 28'(CLK_RESET) * 28'(CLK_MEGA);
			clk_k_q <= 18'(CLK_RESET) * 18'(MS_TO_US);
		end else if (cfg_valid) begin
			clk_m_q <= 28'(timer_clock_mhz) * 28'(CLK_MEGA);
			clk_k_q <= 18'(timer_clock_mhz) * 18'(MS_TO_US);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			elapsed_q <= '0;
			pin_q <= 1'b0;
			enable_q <= 1'b0;
			reload_q <= RELOAD_RESET;
			refused_q <= 1'b0;
			out_valid <= 1'b0;
			div_cnt_q <= '0;
			limit_q <= '0;
			prod_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			pin_level <= 1'b0;
			reload_value <= '0;
			events_enabled <= 1'b0;
			notes_waiting <= '0;
			add_refused <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						refused_q <= 1'b0;
						state_q <= S_DONE;
						case (mode)
							MODE_ADD: begin
								if (wr_en) begin
									count_q <= count_q + CW'(1);
								end else begin
									refused_q <= 1'b1;
								end
							end
							MODE_UPDATE: begin
								if (enable_q && count_q != '0) begin
									state_q <= S_URD;
								end else begin
									enable_q <= 1'b0;
								end
							end
							MODE_START: begin
								enable_q <= 1'b1;
								if (count_q != '0) begin
									state_q <= S_RRD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_URD: begin
					state_q <= S_UHEAD;
				end
				S_UHEAD: begin
					limit_q <= 26'(head_dur) * 26'(MS_TO_US);
					if (head_freq != '0) begin
						quo_q <= DDW'(HALF_MEGA);
						rem_q <= '0;
						dvs_q <= DVW'(head_freq);
						div_cnt_q <= '0;
						state_q <= S_UDIV;
					end else begin
						state_q <= S_POP;
					end
				end
				S_UDIV, S_RDIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[DDW-2:0], rem_ge};
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DDW - 1)) begin
						state_q <= (state_q == S_UDIV) ? S_UACC : S_RSET;
					end
				end
				S_UACC: begin
					pin_q <= ~pin_q;
					elapsed_q <= elapsed_sat;
					state_q <= ({1'b0, elapsed_sat} > 28'(limit_q)) ? S_POP : S_DONE;
				end
				S_POP: begin
					head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
					count_q <= count_q - CW'(1);
					elapsed_q <= '0;
					state_q <= (count_q > CW'(1)) ? S_RRD : S_DONE;
				end
				S_RRD: begin
					state_q <= S_RHEAD;
				end
				S_RHEAD: begin
					if (head_freq != '0) begin
						quo_q <= clk_m_q;
						rem_q <= '0;
						dvs_q <= {head_freq, 1'b0};
						div_cnt_q <= '0;
						state_q <= S_RDIV;
					end else begin
						prod_q <= 34'(clk_k_q) * 34'(head_dur);
						state_q <= S_RMUL;
					end
				end
				S_RSET: begin
					reload_q <= 32'(quo_q);
					state_q <= S_DONE;
				end
				S_RMUL: begin
					reload_q <= (prod_q[33:32] != 2'b00) ? 32'hFFFF_FFFF : prod_q[31:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						pin_level <= pin_q;
						reload_value <= reload_q;
						events_enabled <= enable_q;
						notes_waiting <= 9'(count_q);
						add_refused <= refused_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/nqst_checker.sv =====
// Port-level checks for the note queue square tone player, bound to the top level.
// Depends on nqst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nqst_checker import nqst_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        pin_level,
	input wire logic [31:0] reload_value,
	input wire logic        events_enabled,
	input wire logic [8:0]  notes_waiting,
	input wire logic        add_refused
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reload_value) &&
			$stable(pin_level) && $stable(events_enabled) && $stable(notes_waiting) &&
			$stable(add_refused))
		else $error("stalled result word changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> notes_waiting <= 9'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && add_refused |-> notes_waiting == 9'(QUEUE_DEPTH))
		else $error("add refused with room in the queue");
endmodule

bind note_queue_square_tone_player nqst_checker u_nqst_checker (.*);
`default_nettype wire

// ===== dv/note_queue_square_tone_player_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for note_queue_square_tone_player: a cue table of directed words,
// then random note sequences, a full-queue pass and clock setting changes under stalls.
// Depends on nqst_pkg and the RTL top level only.
module note_queue_square_tone_player_tb;
	import nqst_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 1550;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic        pin;
		logic [31:0] reload;
		logic        enabled;
		logic [8:0]  waiting;
		logic        refused;
	} player_status_t;

	typedef struct {
		logic [1:0]     mode;
		logic [15:0]    freq;
		logic [15:0]    dur;
		bit             typed;
		player_status_t status;
	} cue_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  mode = '0;
	logic [15:0] freq_hz = '0;
	logic [15:0] duration_ms = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_clock_mhz = CLK_RESET;
	logic        in_ready;
	logic        out_valid;
	logic        pin_level;
	logic [31:0] reload_value;
	logic        events_enabled;
	logic [8:0]  notes_waiting;
	logic        add_refused;
	logic        cfg_ready;

	// player state as the bench sees it
	logic [15:0]   ring_freq [QUEUE_DEPTH];
	logic [15:0]   ring_dur [QUEUE_DEPTH];
	logic [AW-1:0] ring_head = '0;
	int            ring_count = 0;
	logic [63:0]   elapsed_time = '0;
	logic          tone_pin = 1'b0;
	logic          events_on = 1'b0;
	logic [31:0]   next_reload = RELOAD_RESET;
	logic [7:0]    tick_mhz = CLK_RESET;

	player_status_t pending_status [$];

	int random_words = 0;
	int notes_played = 0;
	int refused_adds = 0;
	int clock_writes = 0;
	int fault_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit counting = 1'b0;
	bit idling = 1'b1;

	cue_row_t cues [20] = '{
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd0, 1'b0}},
		'{MODE_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd0, 1'b0}},
		'{MODE_START, 16'h0000, 16'h0000, 1'b1, '{1'b0, RELOAD_RESET, 1'b1, 9'd0, 1'b0}},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd0, 1'b0}},
		'{MODE_ADD, 16'h0000, 16'hFFFF, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd1, 1'b0}},
		'{MODE_ADD, 16'hFFFF, 16'h0000, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd2, 1'b0}},
		'{MODE_ADD, 16'd1, 16'd1, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd3, 1'b0}},
		'{MODE_ADD, 16'd1000, 16'd2, 1'b1, '{1'b0, RELOAD_RESET, 1'b0, 9'd4, 1'b0}},
		'{MODE_START, 16'h0000, 16'h0000, 1'b1, '{1'b0, 32'hFFFF_FFFF, 1'b1, 9'd4, 1'b0}},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_START, 16'h0000, 16'h0000, 1'b0, '0},
		'{MODE_UPDATE, 16'h0000, 16'h0000, 1'b0, '0}
	};

	note_queue_square_tone_player DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.freq_hz(freq_hz),
		.duration_ms(duration_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pin_level(pin_level),
		.reload_value(reload_value),
		.events_enabled(events_enabled),
		.notes_waiting(notes_waiting),
		.add_refused(add_refused),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.timer_clock_mhz(cfg_clock_mhz)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] head_reload();
		logic [63:0] f;
		logic [63:0] r;
		f = ring_freq[ring_head];
		if (f != 0)
			r = 64'(tick_mhz) * CLK_MEGA / (2 * f);
		else
			r = 64'(tick_mhz) * MS_TO_US * ring_dur[ring_head];
		if (r > 64'hFFFF_FFFF)
			r = 64'hFFFF_FFFF;
		return r[31:0];
	endfunction

	task automatic advance_player(input logic [1:0] m, input logic [15:0] f,
			input logic [15:0] d, output player_status_t st);
		logic [AW-1:0] slot;
		logic [63:0]   span;
		bit            done;
		st.refused = 1'b0;
		case (m)
			MODE_ADD: begin
				if (ring_count < QUEUE_DEPTH) begin
					slot = ring_head + AW'(ring_count);
					ring_freq[slot] = f;
					ring_dur[slot] = d;
					ring_count++;
				end else begin
					st.refused = 1'b1;
					refused_adds++;
				end
			end
			MODE_UPDATE: begin
				if (events_on && ring_count == 0) begin
					events_on = 1'b0;
				end else if (events_on) begin
					done = 1'b1;
					if (ring_freq[ring_head] != 0) begin
						span = elapsed_time + HALF_MEGA / ring_freq[ring_head];
						elapsed_time = (span > ELAPSED_MAX) ? 64'(ELAPSED_MAX) : span;
						tone_pin = ~tone_pin;
						done = elapsed_time > 64'(ring_dur[ring_head]) * MS_TO_US;
					end
					if (done) begin
						ring_head++;
						ring_count--;
						elapsed_time = '0;
						notes_played++;
						if (ring_count > 0)
							next_reload = head_reload();
					end
				end
			end
			MODE_START: begin
				if (ring_count > 0)
					next_reload = head_reload();
				events_on = 1'b1;
			end
			default: ;
		endcase
		st.pin = tone_pin;
		st.reload = next_reload;
		st.enabled = events_on;
		st.waiting = 9'(ring_count);
	endtask

	task automatic send_word(input logic [1:0] m, input logic [15:0] f, input logic [15:0] d,
			input bit typed = 1'b0, input player_status_t typed_status = '0);
		player_status_t st;
		bit skipped;
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		freq_hz <= f;
		duration_ms <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		skipped = (m == MODE_SPARE) || (m == MODE_UPDATE && !events_on);
		advance_player(m, f, d, st);
		pending_status.push_back(typed ? typed_status : st);
		if (counting && !skipped)
			random_words++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_clock(input logic [7:0] mhz);
		cfg_valid <= 1'b1;
		cfg_clock_mhz <= mhz;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tick_mhz = mhz;
		clock_writes++;
	endtask

	// keep tones short enough to end within about forty updates
	task automatic pick_note(output logic [15:0] f, output logic [15:0] d);
		case ($urandom_range(0, 3))
			0: begin
				f = '0;
				d = 16'($urandom);
			end
			1: begin
				f = 16'($urandom_range(1, 65535));
				d = 16'($urandom_range(0, 20000 / f));
			end
			default: begin
				f = 16'($urandom_range(1, 2000));
				d = 16'($urandom_range(0, 20000 / f));
			end
		endcase
	endtask

	task automatic stray_word();
		logic [1:0] m;
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 2))
				0: m = MODE_UPDATE;
				1: m = MODE_START;
				default: m = MODE_SPARE;
			endcase
			send_word(m, 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic play_out(input int guard);
		logic [15:0] f;
		logic [15:0] d;
		while (events_on && guard > 0) begin
			send_word(MODE_UPDATE, 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 39) == 0) begin
				pick_note(f, d);
				send_word(MODE_ADD, f, d);
			end
			stray_word();
			guard--;
		end
	endtask

	task automatic play_episode();
		logic [15:0] f;
		logic [15:0] d;
		int adds;
		adds = $urandom_range(0, 10);
		repeat (adds) begin
			pick_note(f, d);
			send_word(MODE_ADD, f, d);
			stray_word();
		end
		if ($urandom_range(0, 9) != 0)
			send_word(MODE_START, 16'($urandom), 16'($urandom));
		play_out(600);
	endtask

	// fill to the top, push a few more that must bounce, then drain it
	task automatic fill_queue();
		logic [15:0] f;
		logic [15:0] d;
		while (ring_count < QUEUE_DEPTH) begin
			if ($urandom_range(0, 1) == 0) begin
				f = '0;
				d = 16'($urandom);
			end else begin
				f = 16'($urandom_range(1, 65535));
				d = '0;
			end
			send_word(MODE_ADD, f, d);
		end
		repeat (3) begin
			pick_note(f, d);
			send_word(MODE_ADD, f, d);
		end
		send_word(MODE_START, 16'($urandom), 16'($urandom));
		play_out(1200);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= REPORT_LIMIT)
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(1, 11) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		player_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: result word with nothing outstanding", $time);
			end else begin
				want = pending_status.pop_front();
				check_field("pin_level", 32'(want.pin), 32'(pin_level));
				check_field("reload_value", want.reload, reload_value);
				check_field("events_enabled", 32'(want.enabled), 32'(events_enabled));
				check_field("notes_waiting", 32'(want.waiting), 32'(notes_waiting));
				check_field("add_refused", 32'(want.refused), 32'(add_refused));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", CYCLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] mhz;
		int episode;
		bit queue_filled;
		episode = 0;
		queue_filled = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (cues[i])
			send_word(cues[i].mode, cues[i].freq, cues[i].dur, cues[i].typed, cues[i].status);
		counting = 1'b1;
		while (random_words < RANDOM_WORDS) begin
			if (episode < 2 || $urandom_range(0, 4) == 0) begin
				settle();
				if (episode == 0)
					mhz = 8'd1;
				else if (episode == 1)
					mhz = 8'd255;
				else
					mhz = 8'($urandom_range(1, 255));
				write_clock(mhz);
			end
			idling = (random_words < RANDOM_WORDS * 85 / 100) && ($urandom_range(0, 3) != 0);
			if (!queue_filled && random_words >= RANDOM_WORDS / 3) begin
				queue_filled = 1'b1;
				fill_queue();
			end else begin
				play_episode();
			end
			episode++;
		end
		idling = 1'b0;
		settle();
		repeat (100) @(posedge clk);
		$display("Ran %0d cue words and %0d random words over %0d clock settings.",
			$size(cues), random_words, clock_writes + 1);
		$display("Played out %0d notes, bounced %0d adds off a full queue, %0d faults.",
			notes_played, refused_adds, fault_count);
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
